[src/range_add_point_query_tree_top_assert.svh]
// Assertion macros used by the checker of the range add and point query block.
// Each macro samples on the rising edge of aclk and is disabled while aresetn is low.
`ifndef RANGE_ADD_POINT_QUERY_TREE_TOP_ASSERT_SVH
`define RANGE_ADD_POINT_QUERY_TREE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAPQT_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("rapqt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RAPQT_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("rapqt: next-cycle check failed");

`endif

[src/rapqt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rapqt_pkg;

    localparam int IDX_W     = 10;
    localparam int DATA_W    = 64;
    localparam int CNT_W     = 11;
    localparam int ACT_W     = 2;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 64;

    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

    typedef logic [ACT_W-1:0] action_t;

    localparam action_t ACT_LOAD  = 2'd0;
    localparam action_t ACT_ADD   = 2'd1;
    localparam action_t ACT_QUERY = 2'd2;

    typedef struct packed {
        logic capture;
        logic clr_write;
        logic base_write;
        logic rd_node;
        logic sel_right;
        logic pend_write;
        logic a_inc;
        logic b_dec;
        logic tree_shift;
        logic acc_add;
        logic node_shift;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic    clr_last;
        action_t action;
        logic    first_ok;
        logic    range_ok;
        logic    a_lt_b;
        logic    a_odd;
        logic    b_odd;
        logic    node_last;
        logic    out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[src/rapqt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module rapqt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[src/rapqt_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module rapqt_datapath #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wen,
    input  wire logic [rapqt_pkg::CNT_W-1:0]         cfg_wdata,
    input  wire logic [rapqt_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire rapqt_pkg::action_t                  s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [rapqt_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                     m_tuser,
    input  wire rapqt_pkg::dp_cmd_t                  cmd,
    output rapqt_pkg::dp_status_t                    status
);

    localparam int NODE_W = $clog2(2 * MAX_ELEMENTS + 1);
    localparam int PA_W   = $clog2(2 * MAX_ELEMENTS);
    localparam int BA_W   = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = rapqt_pkg::CNT_W;
    localparam int IDX_W  = rapqt_pkg::IDX_W;
    localparam int DATA_W = rapqt_pkg::DATA_W;

    logic [CNT_W-1:0]      element_count_reg;
    logic [CNT_W-1:0]      count_eff;
    logic [PA_W-1:0]       clr_reg;
    rapqt_pkg::action_t    action_reg;
    logic [IDX_W-1:0]      first_reg;
    logic                  range_ok_reg;
    logic [DATA_W-1:0]     amount_reg;
    logic [NODE_W-1:0]     a_reg;
    logic [NODE_W-1:0]     b_reg;
    logic [NODE_W-1:0]     a_next;
    logic [NODE_W-1:0]     b_next;
    logic [NODE_W-1:0]     b_m1;
    logic [PA_W-1:0]       node_reg;
    logic [DATA_W-1:0]     acc_reg;
    logic                  m_tvalid_reg;
    logic [DATA_W-1:0]     m_tdata_reg;
    logic                  m_tuser_reg;

    logic [IDX_W-1:0]      s_first;
    logic [IDX_W-1:0]      s_last;
    logic [DATA_W-1:0]     s_amount;
    logic [CNT_W-1:0]      last_clip;
    logic                  first_ok;

    logic                  pend_wr_en;
    logic [PA_W-1:0]       pend_wr_addr;
    logic [DATA_W-1:0]     pend_wr_data;
    logic [PA_W-1:0]       pend_rd_addr;
    logic [DATA_W-1:0]     pend_rd_data;
    logic [DATA_W-1:0]     base_rd_data;
    logic [PA_W-1:0]       side_addr;

    assign s_first  = s_tdata[9:0];
    assign s_last   = s_tdata[19:10];
    assign s_amount = s_tdata[83:20];

    assign count_eff = (32'(element_count_reg) > 32'(MAX_ELEMENTS))
                     ? CNT_W'(MAX_ELEMENTS) : element_count_reg;
    assign last_clip = ({1'b0, s_last} >= count_eff) ? count_eff - 1'b1 : {1'b0, s_last};
    assign first_ok  = {1'b0, first_reg} < count_eff;

    assign b_m1      = b_reg - 1'b1;
    assign side_addr = cmd.sel_right ? b_m1[PA_W-1:0] : a_reg[PA_W-1:0];

    always_comb begin
        a_next = cmd.a_inc ? a_reg + 1'b1 : a_reg;
        b_next = cmd.b_dec ? b_m1 : b_reg;
        if (cmd.tree_shift) begin
            a_next = a_next >> 1;
            b_next = b_next >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_count_reg <= rapqt_pkg::CNT_RESET;
            clr_reg           <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_wen) begin
                element_count_reg <= cfg_wdata;
            end
            if (cmd.clr_write) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg   <= s_tuser;
            first_reg    <= s_first;
            range_ok_reg <= s_first <= s_last;
            amount_reg   <= s_amount;
            a_reg        <= NODE_W'(s_first) + NODE_W'(MAX_ELEMENTS);
            b_reg        <= NODE_W'(last_clip) + NODE_W'(MAX_ELEMENTS) + 1'b1;
            node_reg     <= PA_W'(s_first) + PA_W'(MAX_ELEMENTS);
            acc_reg      <= '0;
        end else begin
            a_reg <= a_next;
            b_reg <= b_next;
            if (cmd.node_shift) begin
                node_reg <= node_reg >> 1;
            end
            if (cmd.acc_add) begin
                acc_reg <= acc_reg + pend_rd_data;
            end
        end
        if (cmd.out_load) begin
            m_tdata_reg <= first_ok ? acc_reg + base_rd_data : '0;
            m_tuser_reg <= !first_ok;
        end
    end

    assign pend_wr_en   = cmd.clr_write | cmd.pend_write;
    assign pend_wr_addr = cmd.clr_write ? clr_reg : side_addr;
    assign pend_wr_data = cmd.clr_write ? '0 : pend_rd_data + amount_reg;
    assign pend_rd_addr = cmd.rd_node ? node_reg : side_addr;

    rapqt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (2 * MAX_ELEMENTS)
    ) u_pend_ram (
        .aclk    (aclk),
        .wr_en   (pend_wr_en),
        .wr_addr (pend_wr_addr),
        .wr_data (pend_wr_data),
        .rd_addr (pend_rd_addr),
        .rd_data (pend_rd_data)
    );

    rapqt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_base_ram (
        .aclk    (aclk),
        .wr_en   (cmd.base_write),
        .wr_addr (BA_W'(first_reg)),
        .wr_data (amount_reg),
        .rd_addr (BA_W'(first_reg)),
        .rd_data (base_rd_data)
    );

    assign status.clr_last  = clr_reg == PA_W'(2 * MAX_ELEMENTS - 1);
    assign status.action    = action_reg;
    assign status.first_ok  = first_ok;
    assign status.range_ok  = first_ok && range_ok_reg;
    assign status.a_lt_b    = a_reg < b_reg;
    assign status.a_odd     = a_reg[0];
    assign status.b_odd     = b_reg[0];
    assign status.node_last = node_reg == PA_W'(1);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

[src/rapqt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module rapqt_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire rapqt_pkg::dp_status_t status,
    output rapqt_pkg::dp_cmd_t         cmd
);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DISPATCH = 4'd2;
    localparam logic [3:0] ST_ADD_CHK  = 4'd3;
    localparam logic [3:0] ST_ADD_LRD  = 4'd4;
    localparam logic [3:0] ST_ADD_LWR  = 4'd5;
    localparam logic [3:0] ST_ADD_RCHK = 4'd6;
    localparam logic [3:0] ST_ADD_RRD  = 4'd7;
    localparam logic [3:0] ST_ADD_RWR  = 4'd8;
    localparam logic [3:0] ST_Q_RD     = 4'd9;
    localparam logic [3:0] ST_Q_ACC    = 4'd10;
    localparam logic [3:0] ST_Q_FIN    = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (status.action)
                    rapqt_pkg::ACT_LOAD: begin
                        cmd.base_write = status.first_ok;
                        state_next     = ST_IDLE;
                    end
                    rapqt_pkg::ACT_ADD: begin
                        state_next = status.range_ok ? ST_ADD_CHK : ST_IDLE;
                    end
                    rapqt_pkg::ACT_QUERY: begin
                        state_next = status.first_ok ? ST_Q_RD : ST_Q_FIN;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ADD_CHK: begin
                if (!status.a_lt_b) begin
                    state_next = ST_IDLE;
                end else if (status.a_odd) begin
                    state_next = ST_ADD_LRD;
                end else begin
                    state_next = ST_ADD_RCHK;
                end
            end
            ST_ADD_LRD: begin
                state_next = ST_ADD_LWR;
            end
            ST_ADD_LWR: begin
                cmd.pend_write = 1'b1;
                cmd.a_inc      = 1'b1;
                state_next     = ST_ADD_RCHK;
            end
            ST_ADD_RCHK: begin
                if (status.b_odd) begin
                    state_next = ST_ADD_RRD;
                end else begin
                    cmd.tree_shift = 1'b1;
                    state_next     = ST_ADD_CHK;
                end
            end
            ST_ADD_RRD: begin
                cmd.sel_right = 1'b1;
                state_next    = ST_ADD_RWR;
            end
            ST_ADD_RWR: begin
                cmd.sel_right  = 1'b1;
                cmd.pend_write = 1'b1;
                cmd.b_dec      = 1'b1;
                cmd.tree_shift = 1'b1;
                state_next     = ST_ADD_CHK;
            end
            ST_Q_RD: begin
                cmd.rd_node = 1'b1;
                state_next  = ST_Q_ACC;
            end
            ST_Q_ACC: begin
                cmd.acc_add    = 1'b1;
                cmd.node_shift = 1'b1;
                state_next     = status.node_last ? ST_Q_FIN : ST_Q_RD;
            end
            ST_Q_FIN: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/range_add_point_query_tree_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Array of MAX_ELEMENTS signed 64-bit values with load, range add and point query, one item at
// a time. Range additions are kept as pending sums in a segment tree held in a RAM of
// 2*MAX_ELEMENTS words; base values sit in a second RAM and are added at query time. After
// reset the block clears the tree RAM with s_tready low; the configuration write port is live
// throughout. A query makes one RAM read per level on the path from leaf to root, over
// log2(MAX_ELEMENTS) + 1 tree levels. A range add that touches no position returns to idle
// from dispatch; otherwise it makes two decisions per level plus a read-modify-write for each
// of at most two nodes per level. An out-of-range query answers zero with m_tuser set. A query
// whose result finds the output register still occupied waits in its last state until that
// register frees. A finished result waits in the output register while the next item is
// accepted.
module range_add_point_query_tree_top #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wen,
    input  wire logic [rapqt_pkg::CNT_W-1:0]       cfg_wdata,    // element_count
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [rapqt_pkg::S_TDATA_W-1:0]   s_tdata,      // first_index, last_index, amount
    input  wire rapqt_pkg::action_t                s_tuser,      // action
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [rapqt_pkg::M_TDATA_W-1:0]   m_tdata,      // point_value
    output logic                                   m_tuser       // out_of_range
);

    rapqt_pkg::dp_cmd_t    cmd;
    rapqt_pkg::dp_status_t status;

    rapqt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rapqt_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

[src/rapqt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "range_add_point_query_tree_top_assert.svh"

module rapqt_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire rapqt_pkg::action_t                s_tuser,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [rapqt_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic                              m_tuser
);

    logic in_xfer;
    logic out_wait;
    logic non_query;

    assign in_xfer   = s_tvalid && s_tready;
    assign out_wait  = m_tvalid && !m_tready;
    assign non_query = s_tuser != rapqt_pkg::ACT_QUERY;

    // A result waiting for the sink keeps its value.
    `RAPQT_ASSERT_NEXT(a_out_hold, out_wait, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // An out-of-range answer carries a zero value.
    `RAPQT_ASSERT_SAME(a_oor_zero, m_tvalid && m_tuser, m_tdata == '0)

    // Items are handled one at a time, so ready drops after every transfer.
    `RAPQT_ASSERT_NEXT(a_one_at_a_time, in_xfer, !s_tready)

    // Only a query produces a result.
    `RAPQT_ASSERT_NEXT(a_no_spurious_result, in_xfer && non_query && !m_tvalid, !m_tvalid)

endmodule

bind range_add_point_query_tree_top rapqt_checker u_rapqt_checker (.*);

`default_nettype wire
